>>> hdl/life_like_grid_generation_macros.svh
// assertion macros for the life-like grid generation block
`ifndef LIFE_LIKE_GRID_GENERATION_MACROS_SVH
`define LIFE_LIKE_GRID_GENERATION_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LLGG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define LLGG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/llgg_pkg.sv
// shared constants, types and command/status structs of the grid generation block
`timescale 1ns / 1ps

package llgg_pkg;

   // grid geometry
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 128;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int NR_W     = $clog2(MAX_ROWS + 1);
   localparam int NC_W     = $clog2(MAX_COLS + 1);

   // field widths
   localparam int COMMAND_W   = 2;
   localparam int ROW_FIELD_W = 6;
   localparam int COL_FIELD_W = 7;
   localparam int ROWS_CFG_W  = 7;
   localparam int COLS_CFG_W  = 8;
   localparam int MASK_W      = 9;
   localparam int CNT_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

   // commands
   localparam logic [COMMAND_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_ADVANCE = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_READ    = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BIRTH   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SURVIVE = 2'd3;

   // register reset values
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET    = 7'd40;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET    = 8'd120;
   localparam logic [MASK_W-1:0]     BIRTH_RESET   = 9'h008;
   localparam logic [MASK_W-1:0]     SURVIVE_RESET = 9'h00C;

   // row read address source
   typedef enum logic [1:0] {
      RD_REQ,
      RD_ZERO,
      RD_PLUS1,
      RD_PLUS2
   } rd_sel_type;

   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_cell;
      logic       wr_row;
      logic       cap_read;
      logic       adv_init;
      logic       load_cur;
      logic       load_next;
      logic       step_cell;
      logic       shift_rows;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic                 in_range;
      logic                 area_empty;
      logic                 row_last;
      logic                 col_last;
   } dp_stat_type;

endpackage

>>> hdl/llgg_ctrl.sv
// control state machine: sequences cell access, generation sweep and result beat
`timescale 1ns / 1ps

module llgg_ctrl import llgg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_DECODE     = 3'd1;
   localparam logic [2:0] ST_ACCESS     = 3'd2;
   localparam logic [2:0] ST_LOAD_FIRST = 3'd3;
   localparam logic [2:0] ST_LOAD_NEXT  = 3'd4;
   localparam logic [2:0] ST_CELL       = 3'd5;
   localparam logic [2:0] ST_WRITE_ROW  = 3'd6;
   localparam logic [2:0] ST_DONE       = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       cell_cmd;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign cell_cmd   = (dp_stat.command == CMD_WRITE) || (dp_stat.command == CMD_READ);

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.latch_req = 1'b1;
               state_in         = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (cell_cmd && dp_stat.in_range) begin
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_REQ;
               state_in      = ST_ACCESS;
            end else if ((dp_stat.command == CMD_ADVANCE) && !dp_stat.area_empty) begin
               dp_cmd.adv_init = 1'b1;
               dp_cmd.rd_en    = 1'b1;
               dp_cmd.rd_sel   = RD_ZERO;
               state_in        = ST_LOAD_FIRST;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ACCESS: begin
            if (dp_stat.command == CMD_WRITE) begin
               dp_cmd.wr_cell = 1'b1;
            end else begin
               dp_cmd.cap_read = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_LOAD_FIRST: begin
            dp_cmd.load_cur = 1'b1;
            dp_cmd.rd_en    = 1'b1;
            dp_cmd.rd_sel   = RD_PLUS1;
            state_in        = ST_LOAD_NEXT;
         end
         ST_LOAD_NEXT: begin
            dp_cmd.load_next = 1'b1;
            state_in         = ST_CELL;
         end
         ST_CELL: begin
            dp_cmd.step_cell = 1'b1;
            if (dp_stat.col_last) begin
               state_in = ST_WRITE_ROW;
            end
         end
         ST_WRITE_ROW: begin
            dp_cmd.wr_row     = 1'b1;
            dp_cmd.shift_rows = 1'b1;
            if (dp_stat.row_last) begin
               state_in = ST_DONE;
            end else begin
               // fetch the row below the next one while this row retires
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_PLUS2;
               state_in      = ST_LOAD_NEXT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = dp_cmd.rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/llgg_dp.sv
// datapath: configuration, row memory, three-row window and neighbor count unit
`timescale 1ns / 1ps

module llgg_dp import llgg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             dp_cmd,
   output dp_stat_type            dp_stat,
   input  logic [COMMAND_W-1:0]   req_command,
   input  logic [ROW_FIELD_W-1:0] req_row,
   input  logic [COL_FIELD_W-1:0] req_column,
   input  logic                   req_cell_value,
   input  logic                   csr_wr,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_read_value,
   output logic                   rsp_out_of_range
);

   // configuration
   logic [ROWS_CFG_W-1:0] rows_ff;
   logic [COLS_CFG_W-1:0] cols_ff;
   logic [MASK_W-1:0]     birth_ff, survive_ff;
   logic [NR_W-1:0]       nr;
   logic [NC_W-1:0]       nc;

   // latched request
   logic [COMMAND_W-1:0]   command_ff;
   logic [ROW_FIELD_W-1:0] row_ff;
   logic [COL_FIELD_W-1:0] col_ff;
   logic                   value_ff;
   logic                   res_rd_ff, rsp_rd_ff, rsp_oor_ff;
   logic                   cell_cmd, in_range;

   // row memory, a row valid flag stands for the cleared grid
   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] vld_ff;
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic [MAX_COLS-1:0] rd_row;
   logic [ROW_W-1:0]    mem_ra, mem_wa;
   logic [MAX_COLS-1:0] mem_wd, cell_wd;
   logic                mem_we;
   logic [COL_W-1:0]    col_idx;

   // generation sweep
   logic [ROW_W-1:0]    row_cnt_ff;
   logic [COL_W-1:0]    col_cnt_ff;
   logic [MAX_COLS-1:0] prev_ff, cur_ff, next_ff, newrow_ff;
   logic [COL_W-1:0]    cm1, cp1;
   logic                left_ok, right_ok;
   logic [CNT_W-1:0]    nbr_cnt;
   logic [15:0]         birth_ext, survive_ext;
   logic                new_cell;

   always_comb begin
      nr = (32'(rows_ff) > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(rows_ff);
      nc = (32'(cols_ff) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(cols_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= ROWS_RESET;
         cols_ff    <= COLS_RESET;
         birth_ff   <= BIRTH_RESET;
         survive_ff <= SURVIVE_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_ROWS:    rows_ff    <= csr_wdata[ROWS_CFG_W-1:0];
            REG_COLS:    cols_ff    <= csr_wdata[COLS_CFG_W-1:0];
            REG_BIRTH:   birth_ff   <= csr_wdata[MASK_W-1:0];
            REG_SURVIVE: survive_ff <= csr_wdata[MASK_W-1:0];
         endcase
      end
   end

   assign cell_cmd = (command_ff == CMD_WRITE) || (command_ff == CMD_READ);
   assign in_range = (32'(row_ff) < 32'(nr)) && (32'(col_ff) < 32'(nc));
   assign col_idx  = COL_W'(col_ff);

   always_comb begin
      dp_stat.command    = command_ff;
      dp_stat.in_range   = in_range;
      dp_stat.area_empty = (nr == '0) || (nc == '0);
      dp_stat.row_last   = (NR_W'(row_cnt_ff) + NR_W'(1)) == nr;
      dp_stat.col_last   = (NC_W'(col_cnt_ff) + NC_W'(1)) == nc;
   end

   // memory ports
   assign rd_row = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      unique case (dp_cmd.rd_sel)
         RD_REQ:   mem_ra = ROW_W'(row_ff);
         RD_ZERO:  mem_ra = '0;
         RD_PLUS1: mem_ra = row_cnt_ff + ROW_W'(1);
         RD_PLUS2: mem_ra = row_cnt_ff + ROW_W'(2);
      endcase
   end

   always_comb begin
      cell_wd          = rd_row;
      cell_wd[col_idx] = value_ff;
   end

   assign mem_we = dp_cmd.wr_cell || dp_cmd.wr_row;
   assign mem_wa = dp_cmd.wr_cell ? ROW_W'(row_ff) : row_cnt_ff;
   assign mem_wd = dp_cmd.wr_cell ? cell_wd : newrow_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      if (dp_cmd.rd_en) begin
         rd_data_ff <= grid_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[mem_wa] <= 1'b1;
         end
         if (dp_cmd.rd_en) begin
            rd_vld_ff <= vld_ff[mem_ra];
         end
      end
   end

   // request and result registers
   always_ff @(posedge clock) begin
      if (dp_cmd.latch_req) begin
         command_ff <= req_command;
         row_ff     <= req_row;
         col_ff     <= req_column;
         value_ff   <= req_cell_value;
         res_rd_ff  <= 1'b0;
      end else if (dp_cmd.cap_read) begin
         res_rd_ff <= rd_row[col_idx];
      end
      if (dp_cmd.rsp_load) begin
         rsp_rd_ff  <= res_rd_ff;
         rsp_oor_ff <= cell_cmd && !in_range;
      end
   end

   assign rsp_read_value   = rsp_rd_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // 3x3 window around the current column, off-area neighbors read as dead
   always_comb begin
      cm1         = col_cnt_ff - COL_W'(1);
      cp1         = col_cnt_ff + COL_W'(1);
      left_ok     = (col_cnt_ff != '0);
      right_ok    = (NC_W'(col_cnt_ff) + NC_W'(1)) < nc;
      nbr_cnt     = CNT_W'(prev_ff[cm1] & left_ok) + CNT_W'(prev_ff[col_cnt_ff])
                  + CNT_W'(prev_ff[cp1] & right_ok) + CNT_W'(cur_ff[cm1] & left_ok)
                  + CNT_W'(cur_ff[cp1] & right_ok) + CNT_W'(next_ff[cm1] & left_ok)
                  + CNT_W'(next_ff[col_cnt_ff]) + CNT_W'(next_ff[cp1] & right_ok);
      birth_ext   = 16'(birth_ff);
      survive_ext = 16'(survive_ff);
      new_cell    = cur_ff[col_cnt_ff] ? survive_ext[nbr_cnt] : birth_ext[nbr_cnt];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.adv_init) begin
         row_cnt_ff <= '0;
      end
      if (dp_cmd.load_cur) begin
         prev_ff <= '0;
         cur_ff  <= rd_row;
      end
      if (dp_cmd.load_next) begin
         next_ff    <= dp_stat.row_last ? '0 : rd_row;
         newrow_ff  <= cur_ff;
         col_cnt_ff <= '0;
      end
      if (dp_cmd.step_cell) begin
         newrow_ff[col_cnt_ff] <= new_cell;
         col_cnt_ff            <= col_cnt_ff + COL_W'(1);
      end
      if (dp_cmd.shift_rows) begin
         prev_ff    <= cur_ff;
         cur_ff     <= next_ff;
         row_cnt_ff <= row_cnt_ff + ROW_W'(1);
      end
   end

endmodule

>>> hdl/life_like_grid_generation.sv
// top level of the life-like grid generation block
`timescale 1ns / 1ps
`include "life_like_grid_generation_macros.svh"

// Holds a 64 x 128 one-bit cell grid as one 128-bit row per memory word; a
// per-row valid flag makes the grid read as all dead right after reset, so no
// clearing pass is needed and the block takes beats from the first cycle.
// Commands arrive one beat at a time and each gives exactly one result beat.
// A cell write or read inside the area does one row read, then the bit is
// merged and written back or picked out before the result beat; an access
// outside the area, the unused command and an advance over an empty area go
// straight to the result beat. An advance sweeps the active area (40 x 120 at
// reset, up to the full grid) row by row: the single neighbor count unit
// visits one cell per cycle, and per row a write-back state and a load state
// move the three-row window and write the new row back. A new beat is taken
// once the previous command has finished; its result may still wait in the
// output register.

module life_like_grid_generation import llgg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // row[5:0], column[12:6], cell_value[13]
   input  logic [COMMAND_W-1:0]   req_tuser,   // command[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // read_value[0], out_of_range[1]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic        rsp_read_value, rsp_out_of_range;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {6'b0, rsp_out_of_range, rsp_read_value};

   llgg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   llgg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_stat          (dp_stat),
      .req_command      (req_tuser),
      .req_row          (req_tdata[5:0]),
      .req_column       (req_tdata[12:6]),
      .req_cell_value   (req_tdata[13]),
      .csr_wr           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_read_value   (rsp_read_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   `LLGG_ASSERT_NEXT(a_one_command_at_a_time, clock, reset,
      req_tvalid && req_tready, !req_tready,
      "new beat taken while a command is in progress")
   `LLGG_ASSERT_NOW(a_single_row_write, clock, reset,
      1'b1, $onehot0({dp_cmd.wr_cell, dp_cmd.wr_row}),
      "cell write and row write in the same cycle")
   `LLGG_ASSERT_NOW(a_rsp_from_load, clock, reset,
      $rose(rsp_tvalid), $past(dp_cmd.rsp_load),
      "result beat raised without a result load")

endmodule

>>> tb/tb_life_like_grid_generation.sv
// self-checking testbench for the life-like grid generation block
`timescale 1ns / 1ps

module tb_life_like_grid_generation;
   import llgg_pkg::*;

   localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_OFF_CYCLES = 150;

   typedef struct packed {
      logic read_value;
      logic out_of_range;
   } cell_reply_type;

   typedef struct packed {
      logic [COMMAND_W-1:0]   cmd;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      logic                   val;
      logic                   typed;
      logic                   rd;
      logic                   oor;
   } directed_cmd_type;

   // typed replies only where obvious: fresh grid, in-area writes, outside the area, unused and advance
   localparam directed_cmd_type DIRECTED_CMDS [24] = '{
      '{CMD_READ,    6'd0,  7'd0,   1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,    6'd39, 7'd119, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,    6'd63, 7'd127, 1'b0, 1'b1, 1'b0, 1'b1},
      '{CMD_WRITE,   6'd40, 7'd5,   1'b1, 1'b1, 1'b0, 1'b1},
      '{CMD_WRITE,   6'd5,  7'd120, 1'b1, 1'b1, 1'b0, 1'b1},
      '{CMD_WRITE,   6'd0,  7'd0,   1'b1, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,    6'd0,  7'd0,   1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_WRITE,   6'd39, 7'd119, 1'b1, 1'b0, 1'b0, 1'b0},
      '{CMD_WRITE,   6'd10, 7'd10,  1'b1, 1'b0, 1'b0, 1'b0},
      '{CMD_WRITE,   6'd10, 7'd11,  1'b1, 1'b0, 1'b0, 1'b0},
      '{CMD_WRITE,   6'd10, 7'd12,  1'b1, 1'b0, 1'b0, 1'b0},
      '{CMD_WRITE,   6'd0,  7'd1,   1'b1, 1'b0, 1'b0, 1'b0},
      '{CMD_WRITE,   6'd1,  7'd0,   1'b1, 1'b0, 1'b0, 1'b0},
      '{CMD_UNUSED,  6'd63, 7'd127, 1'b1, 1'b1, 1'b0, 1'b0},
      '{CMD_ADVANCE, 6'd0,  7'd0,   1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,    6'd9,  7'd11,  1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_READ,    6'd10, 7'd10,  1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_READ,    6'd11, 7'd11,  1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_READ,    6'd1,  7'd1,   1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_READ,    6'd39, 7'd119, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_ADVANCE, 6'd63, 7'd127, 1'b1, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,    6'd10, 7'd11,  1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_WRITE,   6'd10, 7'd11,  1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_READ,    6'd63, 7'd0,   1'b0, 1'b1, 1'b0, 1'b1}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [COMMAND_W-1:0]   req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // typed reply travels alongside the beat that causes it
   logic use_typed = 1'b0;
   cell_reply_type typed_reply = '0;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   bit hold_off_req = 1'b0;
   int err_count = 0;
   int quiet_cycles = 0;

   // predictor state
   logic [ROWS_CFG_W-1:0] rows_cfg = ROWS_RESET;
   logic [COLS_CFG_W-1:0] cols_cfg = COLS_RESET;
   logic [MASK_W-1:0]     birth_cfg = BIRTH_RESET;
   logic [MASK_W-1:0]     survive_cfg = SURVIVE_RESET;
   bit life_grid [MAX_ROWS][MAX_COLS];
   cell_reply_type expected_replies [$];

   life_like_grid_generation u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int area_rows();
      return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
   endfunction

   function automatic int area_cols();
      return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
   endfunction

   // next generation from a copy of the grid; cells outside the area stay and count as dead
   function automatic void step_generation();
      bit prior [MAX_ROWS][MAX_COLS];
      int nr, nc, r, c, dr, dc, rr, cc, count;
      prior = life_grid;
      nr = area_rows();
      nc = area_cols();
      for (r = 0; r < nr; r++) begin
         for (c = 0; c < nc; c++) begin
            count = 0;
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
                     count += prior[rr][cc];
               end
            end
            life_grid[r][c] = prior[r][c] ? survive_cfg[count] : birth_cfg[count];
         end
      end
   endfunction

   function automatic cell_reply_type predict_reply(logic [COMMAND_W-1:0] cmd,
                                                    logic [ROW_FIELD_W-1:0] row,
                                                    logic [COL_FIELD_W-1:0] col,
                                                    logic val);
      cell_reply_type reply;
      reply = '0;
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
         if (row >= area_rows() || col >= area_cols())
            reply.out_of_range = 1'b1;
         else if (cmd == CMD_WRITE)
            life_grid[row][col] = val;
         else
            reply.read_value = life_grid[row][col];
      end else if (cmd == CMD_ADVANCE) begin
         step_generation();
      end
      return reply;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin : monitor
      cell_reply_type want;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               REG_ROWS:    rows_cfg = csr_wdata[ROWS_CFG_W-1:0];
               REG_COLS:    cols_cfg = csr_wdata[COLS_CFG_W-1:0];
               REG_BIRTH:   birth_cfg = csr_wdata;
               REG_SURVIVE: survive_cfg = csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            want = predict_reply(req_tuser, req_tdata[5:0], req_tdata[12:6], req_tdata[13]);
            if (use_typed)
               want = typed_reply;
            expected_replies.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (expected_replies.size() == 0) begin
               report_mismatch("reply beat with nothing expected", int'(rsp_tdata), 0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tdata[0] !== want.read_value)
                  report_mismatch("read_value", int'(rsp_tdata[0]), int'(want.read_value));
               if (rsp_tdata[1] !== want.out_of_range)
                  report_mismatch("out_of_range", int'(rsp_tdata[1]),
                                  int'(want.out_of_range));
            end
         end
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("[life_like_grid_generation] ERROR");
               $finish;
            end
         end
      end
   end

   // reply side: random backpressure plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_cmd(logic [COMMAND_W-1:0] cmd, logic [ROW_FIELD_W-1:0] row,
                           logic [COL_FIELD_W-1:0] col, logic val,
                           logic typed, logic rd, logic oor);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {2'b00, val, col, row};
      req_tuser = cmd;
      use_typed = typed;
      typed_reply = '{rd, oor};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_tvalid = 1'b0;
      use_typed = 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index = index;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_cmds(int count, int adv_limit);
      int pick, nr, nc;
      logic [COMMAND_W-1:0]   cmd;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      logic                   val;
      for (int i = 0; i < count; i++) begin
         nr = area_rows();
         nc = area_cols();
         row = ROW_FIELD_W'($urandom_range(0, 63));
         col = COL_FIELD_W'($urandom_range(0, 127));
         val = 1'($urandom_range(0, 1));
         // mostly inside the active area so writes build up patterns
         if (nr > 0 && $urandom_range(0, 99) < 80)
            row = ROW_FIELD_W'($urandom_range(0, nr - 1));
         if (nc > 0 && $urandom_range(0, 99) < 80)
            col = COL_FIELD_W'($urandom_range(0, nc - 1));
         pick = $urandom_range(0, 99);
         if (pick < 12 && adv_limit > 0) begin
            cmd = CMD_ADVANCE;
            adv_limit--;
         end else if (pick < 16) begin
            cmd = CMD_UNUSED;
         end else if (pick < 58) begin
            cmd = CMD_WRITE;
         end else begin
            cmd = CMD_READ;
         end
         send_cmd(cmd, row, col, val, 1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] rows, logic [CSR_DATA_W-1:0] cols,
                            logic [MASK_W-1:0] birth, logic [MASK_W-1:0] survive,
                            int unsigned tx_pct, int unsigned rx_pct,
                            int count, int adv_limit, bit hold);
      drain_replies();
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLS, cols);
      write_reg(REG_BIRTH, birth);
      write_reg(REG_SURVIVE, survive);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      if (hold) begin
         @(posedge clock);
         hold_off_req = 1'b1;
      end
      random_cmds(count, adv_limit);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      tx_idle_pct = 38;
      rx_idle_pct = 53;
      foreach (DIRECTED_CMDS[i])
         send_cmd(DIRECTED_CMDS[i].cmd, DIRECTED_CMDS[i].row, DIRECTED_CMDS[i].col,
                  DIRECTED_CMDS[i].val, DIRECTED_CMDS[i].typed, DIRECTED_CMDS[i].rd,
                  DIRECTED_CMDS[i].oor);

      // oversized area saturates to the full grid, B4678/S35678
      run_phase(9'd127, 9'd255, 9'h1D0, 9'h1E8, 38, 53, 14, 2, 1'b0);
      // 3 x 3 area, B1/S012345678
      run_phase(9'd3, 9'd3, 9'h002, 9'h1FF, 53, 38, 14, 6, 1'b0);
      // empty area: everything out of range, advance changes nothing
      run_phase(9'd0, 9'd5, 9'h1FF, 9'h000, 53, 38, 8, 3, 1'b0);
      // single cell that blinks with every advance
      run_phase(9'd1, 9'd1, 9'h1FF, 9'h000, 0, 0, 8, 5, 1'b0);
      // small area with random rule, long reply hold-off
      run_phase(9'd8, 9'd16, MASK_W'($urandom), MASK_W'($urandom), 0, 0, 20, 6, 1'b1);
      // full grid again, B3/S23, reads back cells left outside the smaller areas
      run_phase(9'd64, 9'd128, 9'h008, 9'h00C, 0, 0, 12, 1, 1'b0);

      drain_replies();
      repeat (20) @(posedge clock);
      if (err_count == 0 && expected_replies.size() == 0) begin
         $display("[life_like_grid_generation] OK");
      end else begin
         $display("[life_like_grid_generation] ERROR");
      end
      $finish;
   end

endmodule

>>> life_like_grid_generation.f
+incdir+hdl
hdl/llgg_pkg.sv
hdl/llgg_ctrl.sv
hdl/llgg_dp.sv
hdl/life_like_grid_generation.sv
tb/tb_life_like_grid_generation.sv
